@@ src/slt_pkg.sv @@
package slt_pkg;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_INSERT = 3'd1,
      OP_DELETE = 3'd2,
      OP_MODIFY = 3'd3,
      OP_GET    = 3'd4
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic       act;
      logic [2:0] op;
   } cell_ctl_type;

endpackage

@@ src/slt_cell.sv @@
module slt_cell #(
   parameter int ID_WIDTH      = 16,
   parameter int PAYLOAD_WIDTH = 32,
   parameter int IDX_W         = 4,
   parameter int INDEX         = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  slt_pkg::cell_ctl_type      ctl,
   input  logic [ID_WIDTH-1:0]        key,
   input  logic [PAYLOAD_WIDTH-1:0]   wdata,
   input  logic [ID_WIDTH-1:0]        new_id,
   input  logic                       sum_hit_i,
   input  logic [IDX_W-1:0]           sum_idx_i,
   input  logic [ID_WIDTH-1:0]        sum_id_i,
   input  logic [PAYLOAD_WIDTH-1:0]   sum_dat_i,
   output logic                       sum_hit_o,
   output logic [IDX_W-1:0]           sum_idx_o,
   output logic [ID_WIDTH-1:0]        sum_id_o,
   output logic [PAYLOAD_WIDTH-1:0]   sum_dat_o
);
   import slt_pkg::*;

   logic                     valid_ff, valid_in;
   logic [ID_WIDTH-1:0]      ident_ff, ident_in;
   logic [PAYLOAD_WIDTH-1:0] data_ff, data_in;

   logic is_ins, is_srch, cand, hit;

   always_comb begin
      is_ins  = (ctl.op == OP_INSERT);
      is_srch = (ctl.op == OP_DELETE) || (ctl.op == OP_MODIFY) || (ctl.op == OP_GET);
      cand    = is_ins ? !valid_ff : (is_srch && valid_ff && (ident_ff == key));
      // a lower slot already claimed the operation
      hit     = ctl.act && cand && !sum_hit_i;

      sum_hit_o = sum_hit_i | hit;
      sum_idx_o = sum_idx_i | (hit ? IDX_W'(INDEX) : '0);
      sum_id_o  = sum_id_i  | (hit ? (is_ins ? new_id : ident_ff) : '0);
      sum_dat_o = sum_dat_i | ((hit && ctl.op == OP_GET) ? data_ff : '0);
   end

   always_comb begin
      valid_in = valid_ff;
      ident_in = ident_ff;
      data_in  = data_ff;
      if (ctl.act && ctl.op == OP_CLEAR) begin
         valid_in = 1'b0;
      end else if (hit) begin
         case (ctl.op)
            OP_INSERT: begin
               valid_in = 1'b1;
               ident_in = new_id;
               data_in  = wdata;
            end
            OP_DELETE: valid_in = 1'b0;
            OP_MODIFY: data_in  = wdata;
            default:   valid_in = valid_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ident_ff <= ident_in;
      data_ff  <= data_in;
   end

endmodule

@@ src/slot_table_with_auto_id.sv @@
// Slot table with automatic identifiers.
// Input channel: a command beat (req_opcode, req_key_id, req_payload) is taken
// at a rising edge where start is high and busy is low. Opcodes: clear, insert,
// delete by id, modify by id, get by id.
// Result channel: exactly one beat per command, shown for one cycle with
// rsp_strobe high; the receiver cannot stall it and must take it then.
// The accepting edge starts the search; busy drops in the same cycle as the
// result strobe is high, so a new command is taken no earlier than that.
// The search runs combinationally through a row of slot cells: each cell
// compares its own entry and passes a claimed flag and the OR of the found
// fields to the next cell, so the lowest matching slot wins.
// Insert fills the lowest free slot with the identifier counter plus one;
// the counter survives clear and wraps at ID_WIDTH bits.
// Failed inserts, failed searches and unknown opcodes report status 1 with
// all other fields zero.
// Reset: every slot free, counter zero, block idle; no clearing pass.
module slot_table_with_auto_id #(
   parameter int ENTRIES       = 16,
   parameter int ID_WIDTH      = 16,
   parameter int PAYLOAD_WIDTH = 32,
   localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [2:0]               req_opcode,
   input  logic [ID_WIDTH-1:0]      req_key_id,
   input  logic [PAYLOAD_WIDTH-1:0] req_payload,
   output logic                     rsp_strobe,
   output logic                     rsp_status,
   output logic [IDX_W-1:0]         rsp_slot_index,
   output logic [ID_WIDTH-1:0]      rsp_entry_id,
   output logic [PAYLOAD_WIDTH-1:0] rsp_record_payload
);
   import slt_pkg::*;

   state_type                state_ff, state_in;
   logic [2:0]               op_ff, op_in;
   logic [ID_WIDTH-1:0]      key_ff, key_in;
   logic [PAYLOAD_WIDTH-1:0] wdata_ff, wdata_in;
   logic [ID_WIDTH-1:0]      next_id_ff, next_id_in;
   logic                     strobe_ff, strobe_in;
   logic                     status_ff, status_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [ID_WIDTH-1:0]      id_ff, id_in;
   logic [PAYLOAD_WIDTH-1:0] dat_ff, dat_in;

   logic                     accept;
   logic [ID_WIDTH-1:0]      new_id;
   cell_ctl_type             ctl;

   logic                     hit_c [ENTRIES+1];
   logic [IDX_W-1:0]         idx_c [ENTRIES+1];
   logic [ID_WIDTH-1:0]      id_c  [ENTRIES+1];
   logic [PAYLOAD_WIDTH-1:0] dat_c [ENTRIES+1];

   assign accept = start && !busy;
   assign new_id = next_id_ff + ID_WIDTH'(1);

   // next state
   always_comb begin
      case (state_ff)
         ST_IDLE:   state_in = accept ? ST_SEARCH : ST_IDLE;
         ST_SEARCH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            busy    = 1'b0;
            ctl.act = 1'b0;
         end
         ST_SEARCH: begin
            busy    = 1'b1;
            ctl.act = 1'b1;
         end
         default: begin
            busy    = 1'b1;
            ctl.act = 1'b0;
         end
      endcase
      ctl.op = op_ff;
   end

   assign hit_c[0] = 1'b0;
   assign idx_c[0] = '0;
   assign id_c[0]  = '0;
   assign dat_c[0] = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      slt_cell #(
         .ID_WIDTH      (ID_WIDTH),
         .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
         .IDX_W         (IDX_W),
         .INDEX         (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .key       (key_ff),
         .wdata     (wdata_ff),
         .new_id    (new_id),
         .sum_hit_i (hit_c[i]),
         .sum_idx_i (idx_c[i]),
         .sum_id_i  (id_c[i]),
         .sum_dat_i (dat_c[i]),
         .sum_hit_o (hit_c[i+1]),
         .sum_idx_o (idx_c[i+1]),
         .sum_id_o  (id_c[i+1]),
         .sum_dat_o (dat_c[i+1])
      );
   end

   always_comb begin
      op_in      = accept ? req_opcode  : op_ff;
      key_in     = accept ? req_key_id  : key_ff;
      wdata_in   = accept ? req_payload : wdata_ff;
      next_id_in = next_id_ff;
      strobe_in  = ctl.act;
      status_in  = status_ff;
      idx_in     = idx_ff;
      id_in      = id_ff;
      dat_in     = dat_ff;
      if (ctl.act) begin
         // advance the counter only when an insert found a free slot
         if (op_ff == OP_INSERT && hit_c[ENTRIES]) begin
            next_id_in = new_id;
         end
         case (op_ff)
            OP_CLEAR:   status_in = 1'b0;
            OP_INSERT,
            OP_DELETE,
            OP_MODIFY,
            OP_GET:     status_in = !hit_c[ENTRIES];
            default:    status_in = 1'b1;
         endcase
         idx_in = idx_c[ENTRIES];
         id_in  = id_c[ENTRIES];
         dat_in = dat_c[ENTRIES];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         next_id_ff <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         next_id_ff <= next_id_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      wdata_ff  <= wdata_in;
      status_ff <= status_in;
      idx_ff    <= idx_in;
      id_ff     <= id_in;
      dat_ff    <= dat_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_slot_index     = idx_ff;
   assign rsp_entry_id       = id_ff;
   assign rsp_record_payload = dat_ff;

endmodule

@@ src/slt_checker.sv @@
module slt_checker #(
   parameter int ENTRIES       = 16,
   parameter int ID_WIDTH      = 16,
   parameter int PAYLOAD_WIDTH = 32,
   parameter int IDX_W         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_strobe,
   input logic                     rsp_status,
   input logic [IDX_W-1:0]         rsp_slot_index,
   input logic [ID_WIDTH-1:0]      rsp_entry_id,
   input logic [PAYLOAD_WIDTH-1:0] rsp_record_payload
);

   // an accepted beat must be answered by a result beat
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("result beat missing two cycles after accept");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status) |->
         (rsp_slot_index == '0 && rsp_entry_id == '0 && rsp_record_payload == '0))
      else $error("failed result carries non-zero fields");

endmodule

bind slot_table_with_auto_id slt_checker #(
   .ENTRIES       (ENTRIES),
   .ID_WIDTH      (ID_WIDTH),
   .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
   .IDX_W         (IDX_W)
) u_slt_checker (.*);
